/* src/rsht_pkg.sv */
`default_nettype none

package rsht_pkg;

    localparam int DEF_MAX_SECTORS      = 32;
    localparam int DEF_COORD_BITS       = 16;
    localparam int DEF_ANGLE_ITERATIONS = 16;

    // register map
    localparam int CFG_IDX_W            = 2;
    localparam int CFG_DATA_W           = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS   = 2'd2;

    localparam int SECT_W   = 6;
    localparam int RADIUS_W = 15;
    localparam int HYST_W   = 13;

    // angle formats
    localparam int ZW           = 26;          // 1/16384 degree accumulator
    localparam int ANG_W        = 15;          // 1/64 degree, [0, 23040)
    localparam int FULL_TURN    = 23040;
    localparam int QUARTER_TURN = 5760;
    localparam int PRESCALE_SH  = 8;
    localparam int HALF_TURN_FINE = 180 * 16384;
    localparam int ANGLE_OFFSET   = 450 * 16384 + 128;
    localparam int FINE_SH        = 8;

    // sector scaling: x / 23040 = (x >> 9) / 45
    localparam int PROD_W       = ANG_W + SECT_W;
    localparam int DIV_PRE_SH   = 9;
    localparam int DIV_V_W      = PROD_W - DIV_PRE_SH;
    localparam int DIV_ODD      = 45;
    localparam int RECIP_45     = 1456;
    localparam int RECIP_SH     = 16;
    localparam int RECIP_W      = 11;
    localparam int QUOT_W       = 7;
    localparam int HN_W         = HYST_W + SECT_W;
    localparam int HB_W         = PROD_W + 2;  // signed window bounds

    typedef struct packed {
        logic                     valid;
        logic signed [SECT_W-1:0] last;
        logic                     dx_zero;
        logic                     dy_zero;
        logic                     dx_neg;
        logic                     dy_pos;
        logic                     near;
    } t_meta;

    function automatic logic signed [ZW-1:0] atan_fine(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = ZW'(737280);
            1:  v = ZW'(435242);
            2:  v = ZW'(229970);
            3:  v = ZW'(116736);
            4:  v = ZW'(58595);
            5:  v = ZW'(29326);
            6:  v = ZW'(14667);
            7:  v = ZW'(7334);
            8:  v = ZW'(3667);
            9:  v = ZW'(1833);
            10: v = ZW'(917);
            11: v = ZW'(458);
            12: v = ZW'(229);
            13: v = ZW'(115);
            14: v = ZW'(57);
            15: v = ZW'(29);
            16: v = ZW'(14);
            17: v = ZW'(7);
            18: v = ZW'(4);
            19: v = ZW'(2);
            20: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/radial_sector_hit_test.sv */
// request path: capture register, cordic stages, p1 to p4, then the output register
// throughput: one request per cycle while the output is not stalled; set by the one-iteration-per-stage cordic
// a stall on the output freezes every stage at once, nothing is dropped
// reset (i_rst_n low, synchronous): pipeline emptied, sector count = 8,
// dead zone radius = 0, hysteresis angle = 0
`default_nettype none

module radial_sector_hit_test #(
    parameter int MAX_SECTORS      = rsht_pkg::DEF_MAX_SECTORS,
    parameter int COORD_BITS       = rsht_pkg::DEF_COORD_BITS,
    parameter int ANGLE_ITERATIONS = rsht_pkg::DEF_ANGLE_ITERATIONS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [rsht_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rsht_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input requests
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic signed [COORD_BITS-1:0]      i_offset_x,
    input  wire logic signed [COORD_BITS-1:0]      i_offset_y,
    input  wire logic signed [rsht_pkg::SECT_W-1:0] i_last_sector,
    // result requests
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [rsht_pkg::SECT_W-1:0]     o_sector_index
);
    import rsht_pkg::*;

    localparam int AI    = ANGLE_ITERATIONS;
    localparam int W     = COORD_BITS + 11;     // cordic x/y, prescale plus growth
    localparam int SQ_W  = 2 * COORD_BITS + 1;
    localparam int R2_W  = 2 * RADIUS_W;
    localparam int CMP_W = (SQ_W > R2_W) ? SQ_W : R2_W;

    // ---------------- configuration registers ----------------
    logic [SECT_W-1:0]   r_sect_cnt;
    logic [RADIUS_W-1:0] r_dead_zone;
    logic [HYST_W-1:0]   r_hyst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sect_cnt     <= SECT_W'(8);
            r_dead_zone    <= '0;
            r_hyst         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SECTOR_COUNT: r_sect_cnt     <= i_cfg_data[SECT_W-1:0];
                CFG_DEAD_ZONE:    r_dead_zone    <= i_cfg_data[RADIUS_W-1:0];
                CFG_HYSTERESIS:   r_hyst         <= i_cfg_data[HYST_W-1:0];
                default: ;
            endcase
        end
    end

    // sector count saturated to what the block supports
    logic [SECT_W-1:0] sect_n;
    assign sect_n = (int'(r_sect_cnt) > MAX_SECTORS) ? SECT_W'(MAX_SECTORS)
                                                      : r_sect_cnt;

    // ---------------- global advance ----------------
    // the whole pipe moves together; it only holds when a finished result waits
    logic en;
    logic r_out_valid;
    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    // ---------------- stage 0: capture, cordic setup, magnitudes ----------------
    logic signed [W-1:0]  r_x [0:AI];
    logic signed [W-1:0]  r_y [0:AI];
    logic signed [ZW-1:0] r_z [0:AI];
    logic signed [W-1:0]  n_x [0:AI];
    logic signed [W-1:0]  n_y [0:AI];
    logic signed [ZW-1:0] n_z [0:AI];
    t_meta                r_meta [0:AI];
    t_meta                n_meta [0:AI];

    logic [COORD_BITS-1:0] r_ax, r_ay;
    logic [COORD_BITS-1:0] n_ax, n_ay;

    logic                  r_near;

    always_comb begin
        logic signed [W-1:0] xe;
        logic signed [W-1:0] ye;
        xe = W'(i_offset_x) <<< PRESCALE_SH;
        ye = W'(i_offset_y) <<< PRESCALE_SH;
        // left half plane: rotate by 180 degrees first
        if (i_offset_x[COORD_BITS-1]) begin
            n_x[0] = -xe;
            n_y[0] = -ye;
            n_z[0] = ZW'(HALF_TURN_FINE);
        end else begin
            n_x[0] = xe;
            n_y[0] = ye;
            n_z[0] = '0;
        end
        n_ax = i_offset_x[COORD_BITS-1] ? (~i_offset_x + 1'b1) : i_offset_x;
        n_ay = i_offset_y[COORD_BITS-1] ? (~i_offset_y + 1'b1) : i_offset_y;
        n_meta[0].valid   = i_valid;
        n_meta[0].last    = i_last_sector;
        n_meta[0].dx_zero = (i_offset_x == '0);
        n_meta[0].dy_zero = (i_offset_y == '0);
        n_meta[0].dx_neg  = i_offset_x[COORD_BITS-1];
        n_meta[0].dy_pos  = !i_offset_y[COORD_BITS-1] && (i_offset_y != '0);
        n_meta[0].near    = 1'b0;

        // cordic vectoring, one iteration per stage
        for (int i = 0; i < AI; i++) begin
            n_meta[i+1] = r_meta[i];
            // dead-zone verdict joins the side data three stages in
            if (i + 1 == 3) n_meta[i+1].near = r_near;
            if (!r_y[i][W-1]) begin
                n_x[i+1] = r_x[i] + (r_y[i] >>> i);
                n_y[i+1] = r_y[i] - (r_x[i] >>> i);
                n_z[i+1] = r_z[i] + atan_fine(i);
            end else begin
                n_x[i+1] = r_x[i] - (r_y[i] >>> i);
                n_y[i+1] = r_y[i] + (r_x[i] >>> i);
                n_z[i+1] = r_z[i] - atan_fine(i);
            end
        end
    end

    // ---------------- dead zone: squares, then sum and compare ----------------
    logic [2*COORD_BITS-1:0] r_sqx, r_sqy;
    logic [R2_W-1:0]         r_r2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqx  <= r_ax * r_ax;
            r_sqy  <= r_ay * r_ay;
            r_r2   <= r_dead_zone * r_dead_zone;
            r_near <= (CMP_W'(r_sqx) + CMP_W'(r_sqy)) < CMP_W'(r_r2);
        end
    end

    // ---------------- cordic stage registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= AI; i++) r_meta[i].valid <= 1'b0;
        end else if (en) begin
            r_ax <= n_ax;
            r_ay <= n_ay;
            for (int i = 0; i <= AI; i++) begin
                r_x[i]    <= n_x[i];
                r_y[i]    <= n_y[i];
                r_z[i]    <= n_z[i];
                r_meta[i] <= n_meta[i];
            end
        end
    end

    // ---------------- p1: angle in 1/64 degree, axis cases ----------------
    logic                      r_p1_valid;
    logic [ANG_W-1:0]          r_p1_u;
    logic [SECT_W-1:0]         r_p1_n;
    logic                      r_p1_miss;
    logic signed [SECT_W-1:0]  r_p1_last;
    logic [ANG_W-1:0]          n_p1_u;

    always_comb begin
        logic signed [ZW-1:0] zsum;
        logic signed [ZW-1:0] t;
        zsum = r_z[AI] + ZW'(ANGLE_OFFSET);
        t    = zsum >>> FINE_SH;
        if (t >= ZW'(2 * FULL_TURN))   n_p1_u = ANG_W'(t - ZW'(2 * FULL_TURN));
        else if (t >= ZW'(FULL_TURN))  n_p1_u = ANG_W'(t - ZW'(FULL_TURN));
        else                           n_p1_u = ANG_W'(t);
        // exact angles on the axes; zero offset points right
        if (r_meta[AI].dy_zero)
            n_p1_u = r_meta[AI].dx_neg ? ANG_W'(3 * QUARTER_TURN) : ANG_W'(QUARTER_TURN);
        else if (r_meta[AI].dx_zero)
            n_p1_u = r_meta[AI].dy_pos ? ANG_W'(2 * QUARTER_TURN) : '0;
    end

    // ---------------- p2: scale by sector count ----------------
    logic                     r_p2_valid;
    logic [PROD_W-1:0]        r_p2_prod;
    logic [HN_W-1:0]          r_p2_hn;
    logic [PROD_W-1:0]        r_p2_m;
    logic [SECT_W-1:0]        r_p2_n;
    logic                     r_p2_miss;
    logic signed [SECT_W-1:0] r_p2_last;

    // ---------------- p3: quotient estimate, raw window bounds ----------------
    logic                     r_p3_valid;
    logic [DIV_V_W-1:0]       r_p3_v;
    logic [QUOT_W-1:0]        r_p3_q0;
    logic signed [HB_W-1:0]   r_p3_s;
    logic signed [HB_W-1:0]   r_p3_e;
    logic [PROD_W-1:0]        r_p3_m;
    logic [PROD_W-1:0]        r_p3_a;
    logic [SECT_W-1:0]        r_p3_n;
    logic                     r_p3_miss;
    logic signed [SECT_W-1:0] r_p3_last;

    logic [DIV_V_W-1:0]       n_p3_v;
    logic [QUOT_W-1:0]        n_p3_q0;
    logic signed [HB_W-1:0]   n_p3_s;
    logic signed [HB_W-1:0]   n_p3_e;

    always_comb begin
        logic signed [HB_W-1:0] base;
        n_p3_v  = r_p2_prod[PROD_W-1:DIV_PRE_SH];
        n_p3_q0 = QUOT_W'(((DIV_V_W + RECIP_W)'(n_p3_v)
                          * (DIV_V_W + RECIP_W)'(RECIP_45)) >> RECIP_SH);
        base    = HB_W'(r_p2_last) * HB_W'(FULL_TURN);
        n_p3_s  = base - HB_W'(r_p2_hn);
        n_p3_e  = base + HB_W'(FULL_TURN) + HB_W'(r_p2_hn);
    end

    // ---------------- p4: exact sector, wrapped window ----------------
    logic                     r_p4_valid;
    logic [SECT_W-1:0]        r_p4_idx;
    logic [PROD_W-1:0]        r_p4_s;
    logic [PROD_W-1:0]        r_p4_e;
    logic [PROD_W-1:0]        r_p4_a;
    logic [SECT_W-1:0]        r_p4_n;
    logic                     r_p4_miss;
    logic signed [SECT_W-1:0] r_p4_last;

    logic [SECT_W-1:0]        n_p4_idx;
    logic [PROD_W-1:0]        n_p4_s;
    logic [PROD_W-1:0]        n_p4_e;

    always_comb begin
        logic [DIV_V_W-1:0] rem;
        logic [QUOT_W-1:0]  q;
        rem = r_p3_v - DIV_V_W'(r_p3_q0) * DIV_V_W'(DIV_ODD);
        q   = (rem >= DIV_V_W'(DIV_ODD)) ? r_p3_q0 + 1'b1 : r_p3_q0;
        // clamp to the last sector
        if (q > QUOT_W'(r_p3_n) - 1'b1) n_p4_idx = r_p3_n - 1'b1;
        else                            n_p4_idx = SECT_W'(q);
        n_p4_s = r_p3_s[HB_W-1] ? PROD_W'(r_p3_s + HB_W'(r_p3_m)) : PROD_W'(r_p3_s);
        n_p4_e = (r_p3_e >= HB_W'(r_p3_m)) ? PROD_W'(r_p3_e - HB_W'(r_p3_m))
                                           : PROD_W'(r_p3_e);
    end

    // ---------------- p5: hysteresis decision, output register ----------------
    logic signed [SECT_W-1:0] r_out_sector;
    logic signed [SECT_W-1:0] n_out_sector;

    always_comb begin
        logic keep_ok;
        logic in_win;
        keep_ok = !r_p4_last[SECT_W-1] && (SECT_W'(r_p4_last) < r_p4_n)
                  && (SECT_W'(r_p4_last) != r_p4_idx);
        // window may wrap past a full turn
        if (r_p4_s <= r_p4_e) in_win = (r_p4_a >= r_p4_s) && (r_p4_a <= r_p4_e);
        else                  in_win = (r_p4_a >= r_p4_s) || (r_p4_a <= r_p4_e);
        if (r_p4_miss)                n_out_sector = '1;
        else if (keep_ok && in_win)   n_out_sector = r_p4_last;
        else                          n_out_sector = r_p4_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_p4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_p1_valid  <= r_meta[AI].valid;
            r_p2_valid  <= r_p1_valid;
            r_p3_valid  <= r_p2_valid;
            r_p4_valid  <= r_p3_valid;
            r_out_valid <= r_p4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_u    <= n_p1_u;
            r_p1_n    <= sect_n;
            r_p1_miss <= r_meta[AI].near || (sect_n == '0);
            r_p1_last <= r_meta[AI].last;

            r_p2_prod <= PROD_W'(r_p1_u) * PROD_W'(r_p1_n);
            r_p2_hn   <= HN_W'(r_hyst) * HN_W'(r_p1_n);
            r_p2_m    <= PROD_W'(r_p1_n) * PROD_W'(FULL_TURN);
            r_p2_n    <= r_p1_n;
            r_p2_miss <= r_p1_miss;
            r_p2_last <= r_p1_last;

            r_p3_v    <= n_p3_v;
            r_p3_q0   <= n_p3_q0;
            r_p3_s    <= n_p3_s;
            r_p3_e    <= n_p3_e;
            r_p3_m    <= r_p2_m;
            r_p3_a    <= r_p2_prod;
            r_p3_n    <= r_p2_n;
            r_p3_miss <= r_p2_miss;
            r_p3_last <= r_p2_last;

            r_p4_idx  <= n_p4_idx;
            r_p4_s    <= n_p4_s;
            r_p4_e    <= n_p4_e;
            r_p4_a    <= r_p3_a;
            r_p4_n    <= r_p3_n;
            r_p4_miss <= r_p3_miss;
            r_p4_last <= r_p3_last;

            r_out_sector <= n_out_sector;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sector_index = r_out_sector;

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps

import rsht_pkg::*;

// expected sector indexes, worked out from the pointer offsets as requests go in
class sector_scoreboard;
    bit [5:0]  sect_cnt;
    bit [14:0] dz_radius;
    bit [12:0] hyst;
    logic [5:0] sector_q[$];
    int unsigned n_in;
    int unsigned n_out;
    int unsigned n_bad;
    int unsigned n_kept;
    int unsigned n_dead;

    function void reset_regs();
        sect_cnt  = 6'd8;
        dz_radius = '0;
        hyst      = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SECTOR_COUNT: sect_cnt  = data[5:0];
            CFG_DEAD_ZONE:    dz_radius = data[14:0];
            CFG_HYSTERESIS:   hyst      = data[12:0];
            default: ;
        endcase
    endfunction

    function longint wrap(longint a, longint m);
        longint r;
        r = a % m;
        if (r < 0)
            r += m;
        return r;
    endfunction

    // clockwise from straight up, 1/64 degree, [0, 23040)
    function longint pointer_angle(longint dx, longint dy);
        longint x, y, z, xs, ys;
        longint atan_tab[16];
        atan_tab = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                     3667, 1833, 917, 458, 229, 115, 57, 29};
        // exact angles on the axes, zero offset points right
        if (dy == 0)
            return (dx < 0) ? 3 * QUARTER_TURN : QUARTER_TURN;
        if (dx == 0)
            return (dy > 0) ? 2 * QUARTER_TURN : 0;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        // left half plane: rotate by half a turn first
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 180 * 16384;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z += atan_tab[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z -= atan_tab[i];
            end
        end
        z += 450 * 16384;
        return wrap((z + 128) >>> 8, FULL_TURN);
    endfunction

    function void note_request(logic signed [15:0] ox, logic signed [15:0] oy,
                               logic signed [5:0] last);
        longint dx, dy, p, n, h, u, idx, m, a, s, e, res;
        bit hit_win;
        dx = ox;
        dy = oy;
        p = last;
        n = (sect_cnt > 32) ? 32 : sect_cnt;
        h = hyst;
        res = -1;
        if (n > 0 && dx * dx + dy * dy >= longint'(dz_radius) * dz_radius) begin
            u = pointer_angle(dx, dy);
            idx = (u * n) / FULL_TURN;
            if (idx > n - 1)
                idx = n - 1;
            res = idx;
            // keep a different valid last sector inside its widened window
            if (p >= 0 && p < n && p != idx) begin
                m = longint'(FULL_TURN) * n;
                a = wrap(u * n, m);
                s = wrap(p * FULL_TURN - h * n, m);
                e = wrap((p + 1) * FULL_TURN + h * n, m);
                if (s <= e)
                    hit_win = (a >= s) && (a <= e);
                else
                    hit_win = (a >= s) || (a <= e);
                if (hit_win) begin
                    res = p;
                    n_kept++;
                end
            end
        end else begin
            n_dead++;
        end
        sector_q.push_back(res[5:0]);
        n_in++;
    endfunction

    function void check_result(logic [5:0] got);
        logic [5:0] want;
        n_out++;
        if (sector_q.size() == 0) begin
            n_bad++;
            if (n_bad <= 10)
                $display("unexpected result sector_index=%0d", $signed(got));
            return;
        end
        want = sector_q.pop_front();
        if (got !== want) begin
            n_bad++;
            if (n_bad <= 10)
                $display("sector_index mismatch on result %0d: expected %0d got %0d",
                         n_out, $signed(want), $signed(got));
        end
    endfunction

    function int pending();
        return sector_q.size();
    endfunction
endclass

module tb_top;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_stall;
    logic signed [15:0]     i_offset_x;
    logic signed [15:0]     i_offset_y;
    logic signed [5:0]      i_last_sector;
    logic                   o_valid;
    logic                   i_stall;
    logic signed [5:0]      o_sector_index;

    sector_scoreboard sb;
    bit                long_hold_req;
    int                n_phases;

    radial_sector_hit_test u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_offset_x     (i_offset_x),
        .i_offset_y     (i_offset_y),
        .i_last_sector  (i_last_sector),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sector_index (o_sector_index)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watch both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_request(i_offset_x, i_offset_y, i_last_sector);
            if (o_valid && !i_stall)
                sb.check_result(o_sector_index);
        end
    end

    // receiver: stall probability changes per window, zero in some windows,
    // plus one long hold-off on request so the pipeline backs up
    initial begin
        int hold_left;
        int win_left;
        int pct;
        hold_left = 0;
        win_left = 0;
        pct = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                if (win_left == 0) begin
                    win_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 3))
                        0: pct = 0;
                        1: pct = 20;
                        2: pct = 50;
                        default: pct = 80;
                    endcase
                end
                win_left--;
                i_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    // hard stop
    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    // one request, held until accepted; valid stays high for the next one
    task automatic send_request(logic signed [15:0] ox, logic signed [15:0] oy,
                                logic signed [5:0] last);
        i_valid       <= 1'b1;
        i_offset_x    <= ox;
        i_offset_y    <= oy;
        i_last_sector <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, data[CFG_DATA_W-1:0]);
    endtask

    // wait for every result, then cover the pipeline depth before touching registers
    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (sb.pending() != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_regs(int unsigned cnt, int unsigned rad, int unsigned hy);
        drain();
        write_reg(CFG_SECTOR_COUNT, cnt);
        write_reg(CFG_DEAD_ZONE, rad);
        write_reg(CFG_HYSTERESIS, hy);
        n_phases++;
    endtask

    // random request: mostly valid last sectors so the hysteresis window is exercised
    task automatic random_request();
        logic signed [15:0] ox, oy;
        logic signed [5:0]  last;
        int n;
        n = (sb.sect_cnt > 32) ? 32 : sb.sect_cnt;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                ox = 16'($urandom);
                oy = 16'($urandom);
            end
            4, 5: begin
                ox = 16'($signed($urandom_range(0, 128)) - 64);
                oy = 16'($signed($urandom_range(0, 128)) - 64);
            end
            6: begin
                // on an axis
                ox = $urandom_range(0, 1) ? 16'sd0 : 16'($urandom);
                oy = (ox == 0) ? 16'($urandom) : 16'sd0;
            end
            7: begin
                // around the dead zone edge
                ox = 16'($signed({17'd0, sb.dz_radius}) + $signed($urandom_range(0, 4)) - 2);
                oy = 16'($signed($urandom_range(0, 4)) - 2);
                if ($urandom_range(0, 1))
                    {ox, oy} = {oy, ox};
            end
            default: begin
                ox = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
                oy = $urandom_range(0, 2) == 0 ? 16'($urandom) :
                     ($urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff);
            end
        endcase
        if (n > 0 && $urandom_range(0, 9) < 7)
            last = 6'($urandom_range(0, n - 1));
        else
            last = 6'($urandom);
        send_request(ox, oy, last);
    endtask

    task automatic random_phase(int count);
        int burst;
        burst = $urandom_range(1, 30);
        for (int i = 0; i < count; i++) begin
            random_request();
            burst--;
            if (burst == 0) begin
                // no gap after some bursts, so valid stays high across them
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 10));
                burst = $urandom_range(1, 30);
            end
        end
    endtask

    initial begin
        sb = new();
        sb.reset_regs();
        n_phases = 0;
        long_hold_req = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_offset_x    = '0;
        i_offset_y    = '0;
        i_last_sector = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset register values: axes, zero offset, extremes, hysteresis
        send_request(16'sd0, 16'sd0, -6'sd1);
        send_request(16'sd100, 16'sd0, 6'sd0);
        send_request(-16'sd100, 16'sd0, 6'sd0);
        send_request(16'sd0, 16'sd100, 6'sd1);
        send_request(16'sd0, -16'sd100, 6'sd7);
        send_request(16'sh7fff, 16'sh7fff, -6'sd1);
        send_request(16'sh8000, 16'sh8000, 6'sd31);
        send_request(16'sh8000, 16'sh7fff, -6'sd32);
        send_request(16'sh7fff, 16'sh8000, 6'sd8);
        send_request(16'sd1, -16'sd1, 6'sd3);
        send_request(-16'sd1, -16'sd1, 6'sd6);
        send_request(-16'sd1, 16'sd1, 6'sd4);
        set_regs(8, 0, 5760);
        send_request(16'sd1000, -16'sd10, 6'sd1);   // last sector is also the new one
        send_request(-16'sd1000, -16'sd10, 6'sd1);
        send_request(16'sd5, -16'sd1000, 6'sd7);    // window wraps past zero
        set_regs(5, 200, 8191);
        send_request(16'sd199, 16'sd0, 6'sd2);      // inside dead zone
        send_request(16'sd200, 16'sd0, 6'sd2);      // on its edge
        send_request(16'sd120, 16'sd160, 6'sd0);
        set_regs(0, 0, 0);
        send_request(16'sd300, 16'sd40, 6'sd0);     // no sectors
        set_regs(63, 0, 100);
        send_request(-16'sd300, -16'sd1, 6'sd31);   // count saturates
        send_request(16'sd300, -16'sd2, 6'sd31);

        // random phases across register settings, extremes included
        set_regs(8, 0, 0);
        long_hold_req = 1'b1;                       // back up the pipeline once
        random_phase(115);
        set_regs(32, 0, 64);
        random_phase(115);
        set_regs(1, 100, 0);
        random_phase(100);
        set_regs(63, 32767, 8191);
        random_phase(60);
        set_regs(0, 0, 0);
        random_phase(40);
        set_regs(3, 16, 5760);
        random_phase(115);
        set_regs(32, 1, 8191);
        random_phase(115);
        for (int k = 0; k < 4; k++) begin
            set_regs($urandom_range(0, 63), $urandom_range(0, 2000), $urandom_range(0, 8191));
            random_phase(115);
        end

        drain();
        $display("covered %0d requests over %0d register settings", sb.n_in, n_phases + 1);
        $display("%0d kept by hysteresis, %0d in dead zone or with no sectors",
                 sb.n_kept, sb.n_dead);
        if (sb.pending() != 0)
            $display("%0d expected results never arrived", sb.pending());
        if (sb.n_bad > 10)
            $display("%0d mismatches in total", sb.n_bad);
        if (sb.n_bad == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
